[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a full property on every clock edge outside of reset.
`define ALUX_ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checks a plain condition on every clock edge outside of reset.
`define ALUX_ASSERT_COND(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("condition failed");

`endif

[sv/alux_pkg.sv]
// Shared widths, codes and coefficient tables of the lux calculator.
`default_nettype none

package alux_pkg;

    // Field and datapath widths.
    localparam int RAW_W      = 16;
    localparam int SCALE_FRAC = 10;
    localparam int RATIO_FRAC = 9;
    localparam int LUX_FRAC   = 14;
    localparam int BASE_W     = 15;
    localparam int GAIN_SHIFT = 4;
    localparam int SCALE_W    = BASE_W + GAIN_SHIFT;
    localparam int C_W        = RAW_W + SCALE_W - SCALE_FRAC;
    localparam int COEF_W     = 10;
    localparam int THR_W      = COEF_W + 1;
    localparam int PROD_W     = C_W + THR_W;
    localparam int SHIFT_W    = C_W + RATIO_FRAC + 1;
    localparam int MUL_W      = C_W + COEF_W;
    localparam int LUX_W      = 21;
    localparam int NSEG       = 8;
    localparam int NBRK       = NSEG - 1;
    localparam int SEG_W      = 3;

    // Configuration port.
    localparam int CFG_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ITIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'b1;

    // Integration time codes; all other codes mean nominal.
    localparam logic [1:0] ITIME_FAST    = 2'd0;
    localparam logic [1:0] ITIME_MID     = 2'd1;
    localparam logic [1:0] ITIME_NOMINAL = 2'd2;

    // Scale factors with SCALE_FRAC fractional bits.
    localparam logic [BASE_W-1:0] SCALE_FAST = 15'h7517;
    localparam logic [BASE_W-1:0] SCALE_MID  = 15'h0fe7;
    localparam logic [BASE_W-1:0] SCALE_UNIT = 15'h0400;

    // Ratio breakpoints and segment coefficients.
    localparam logic [COEF_W-1:0] SEG_BREAK [NBRK] = '{
        10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a
    };
    localparam logic [COEF_W-1:0] SEG_B [NSEG] = '{
        10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
    };
    localparam logic [COEF_W-1:0] SEG_M [NSEG] = '{
        10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
    };

    // Scaled channel pair moving down the pipeline.
    typedef struct packed {
        logic           valid;
        logic [C_W-1:0] c0;
        logic [C_W-1:0] c1;
    } alux_chan_t;

    // Scaled channel pair with its segment coefficients.
    typedef struct packed {
        logic              valid;
        logic [C_W-1:0]    c0;
        logic [C_W-1:0]    c1;
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] m;
    } alux_coef_t;

endpackage

`default_nettype wire

[sv/alux_seg_sel.sv]
// Two-stage segment selection from the infrared to broadband ratio.
`default_nettype none

module alux_seg_sel (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire alux_pkg::alux_chan_t chan_in,
    output alux_pkg::alux_coef_t     coef_out
);
    import alux_pkg::*;

    // Stage A registers: threshold products and shifted infrared count.
    logic                        a_valid_reg;
    logic [C_W-1:0]              a_c0_reg;
    logic [C_W-1:0]              a_c1_reg;
    logic                        a_zero_reg;
    logic [SHIFT_W-1:0]          a_c1sh_reg;
    logic [PROD_W-1:0]           a_thr_reg [NBRK];
    logic [PROD_W-1:0]           a_thr_next [NBRK];

    // Stage B registers: chosen coefficients.
    logic                        b_valid_reg;
    logic [C_W-1:0]              b_c0_reg;
    logic [C_W-1:0]              b_c1_reg;
    logic [COEF_W-1:0]           b_b_reg;
    logic [COEF_W-1:0]           b_m_reg;
    logic [SEG_W-1:0]            seg_next;
    logic [NBRK-1:0]             below;

    // The rounded ratio is at most a breakpoint B exactly when
    // c1 * 2^10 < c0 * (2B + 1), so each breakpoint becomes one product.
    always_comb
    begin
        for (int k = 0; k < NBRK; k++)
        begin
            a_thr_next[k] = PROD_W'(chan_in.c0) * PROD_W'({SEG_BREAK[k], 1'b1});
        end
    end

    // Stage A valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= chan_in.valid;
        end
    end

    // Stage A payload.
    always_ff @(posedge clk)
    begin
        a_c0_reg   <= chan_in.c0;
        a_c1_reg   <= chan_in.c1;
        a_zero_reg <= (chan_in.c0 == '0);
        a_c1sh_reg <= {chan_in.c1, {(RATIO_FRAC + 1){1'b0}}};
        for (int k = 0; k < NBRK; k++)
        begin
            a_thr_reg[k] <= a_thr_next[k];
        end
    end

    // Compare against every breakpoint and take the first one that holds.
    always_comb
    begin
        for (int k = 0; k < NBRK; k++)
        begin
            below[k] = (PROD_W'(a_c1sh_reg) < a_thr_reg[k]);
        end
        seg_next = SEG_W'(NSEG - 1);
        for (int k = NBRK - 1; k >= 0; k--)
        begin
            if (below[k])
            begin
                seg_next = SEG_W'(k);
            end
        end
        // A zero broadband count gives a ratio of zero.
        if (a_zero_reg)
        begin
            seg_next = '0;
        end
    end

    // Stage B valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    // Stage B payload.
    always_ff @(posedge clk)
    begin
        b_c0_reg <= a_c0_reg;
        b_c1_reg <= a_c1_reg;
        b_b_reg  <= SEG_B[seg_next];
        b_m_reg  <= SEG_M[seg_next];
    end

    assign coef_out.valid = b_valid_reg;
    assign coef_out.c0    = b_c0_reg;
    assign coef_out.c1    = b_c1_reg;
    assign coef_out.b     = b_b_reg;
    assign coef_out.m     = b_m_reg;

endmodule

`default_nettype wire

[sv/ambient_light_lux_calc.sv]
// Throughput: one sample pair per cycle; busy is always low and the pipeline never stalls.
// The five register stages are: channel scaling, ratio threshold products,
// segment choice, coefficient products, and difference with rounding.
// Reset clears all valid bits and sets the integration code to nominal and the gain to 1x.
`default_nettype none

module ambient_light_lux_calc (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [alux_pkg::RAW_W-1:0]    broadband_count,
    input  wire logic [alux_pkg::RAW_W-1:0]    infrared_count,
    output logic                               done,
    output logic [alux_pkg::LUX_W-1:0]         lux,
    input  wire logic                          cfg_we,
    input  wire logic [alux_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [alux_pkg::CFG_W-1:0]    cfg_data
);
    import alux_pkg::*;

    localparam logic [MUL_W:0] ROUND_HALF = (MUL_W + 1)'(1) << (LUX_FRAC - 1);

    logic [1:0]           itime_reg;
    logic                 gain_reg;
    logic [BASE_W-1:0]    base_scale;
    logic [SCALE_W-1:0]   scale;
    logic [RAW_W+SCALE_W-1:0] c0_prod;
    logic [RAW_W+SCALE_W-1:0] c1_prod;
    logic                 accept;

    logic                 s1_valid_reg;
    logic [C_W-1:0]       s1_c0_reg;
    logic [C_W-1:0]       s1_c1_reg;
    alux_chan_t           s1_chan;
    alux_coef_t           coef;

    logic                 s4_valid_reg;
    logic [MUL_W-1:0]     s4_pos_reg;
    logic [MUL_W-1:0]     s4_neg_reg;

    logic [MUL_W-1:0]     diff;
    logic [MUL_W:0]       rounded;
    logic                 done_reg;
    logic [LUX_W-1:0]     lux_reg;

    // Configuration writes; only the register's low bits are kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itime_reg <= ITIME_NOMINAL;
            gain_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ITIME: itime_reg <= cfg_data[1:0];
                REG_GAIN:  gain_reg  <= cfg_data[0];
            endcase
        end
    end

    // Scale factor for integration time and gain.
    always_comb
    begin
        case (itime_reg)
            ITIME_FAST: base_scale = SCALE_FAST;
            ITIME_MID:  base_scale = SCALE_MID;
            default:    base_scale = SCALE_UNIT;
        endcase
        if (gain_reg)
        begin
            scale = SCALE_W'(base_scale);
        end
        else
        begin
            scale = {base_scale, {GAIN_SHIFT{1'b0}}};
        end
    end

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign c0_prod = (RAW_W + SCALE_W)'(broadband_count) * (RAW_W + SCALE_W)'(scale);
    assign c1_prod = (RAW_W + SCALE_W)'(infrared_count) * (RAW_W + SCALE_W)'(scale);

    // Stage 1: scaled channel counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_c0_reg <= c0_prod[RAW_W+SCALE_W-1:SCALE_FRAC];
        s1_c1_reg <= c1_prod[RAW_W+SCALE_W-1:SCALE_FRAC];
    end

    assign s1_chan.valid = s1_valid_reg;
    assign s1_chan.c0    = s1_c0_reg;
    assign s1_chan.c1    = s1_c1_reg;

    // Stages 2 and 3: segment choice.
    alux_seg_sel u_seg_sel (
        .clk      (clk),
        .rst_n    (rst_n),
        .chan_in  (s1_chan),
        .coef_out (coef)
    );

    // Stage 4: intercept and slope products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= coef.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_pos_reg <= MUL_W'(coef.c0) * MUL_W'(coef.b);
        s4_neg_reg <= MUL_W'(coef.c1) * MUL_W'(coef.m);
    end

    // Difference clamped at zero, then rounded half up.
    always_comb
    begin
        if (s4_neg_reg >= s4_pos_reg)
        begin
            diff = '0;
        end
        else
        begin
            diff = s4_pos_reg - s4_neg_reg;
        end
        rounded = (MUL_W + 1)'(diff) + ROUND_HALF;
    end

    // Stage 5: result register and strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lux_reg <= rounded[LUX_FRAC+LUX_W-1:LUX_FRAC];
    end

    assign done = done_reg;
    assign lux  = lux_reg;

endmodule

`default_nettype wire

[sv/alux_checker.sv]
// Port-level checker for the lux calculator and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module alux_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [15:0] broadband_count,
    input  wire logic        done,
    input  wire logic [20:0] lux
);

    // Every transfer in yields exactly one result after the fixed latency.
    `ALUX_ASSERT_PROP(a_result_follows, clk, rst_n, (start && !busy) |-> ##5 done)
    `ALUX_ASSERT_PROP(a_no_stray_result, clk, rst_n, done |-> $past(start && !busy, 5))

    // A dark broadband channel always gives zero lux.
    `ALUX_ASSERT_PROP(a_dark_is_zero, clk, rst_n,
        (start && !busy && broadband_count == 16'd0) |-> ##5 (lux == 21'd0))

    // The pipeline never pushes back on the sender.
    `ALUX_ASSERT_COND(a_never_busy, clk, rst_n, !busy)

endmodule

bind ambient_light_lux_calc alux_checker u_alux_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .broadband_count (broadband_count),
    .done            (done),
    .lux             (lux)
);

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the ambient light lux calculator.
`default_nettype none

module testbench;

    import alux_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int PIPE_LATENCY  = 4;
    localparam int PHASE_ITEMS   = 250;
    localparam int NUM_PHASES    = 8;
    localparam int MAX_REPORTS   = 10;

    // Scale factors with ten fractional bits, per integration time.
    localparam logic [63:0] SCALE_13MS  = 64'h7517;
    localparam logic [63:0] SCALE_101MS = 64'h0fe7;
    localparam logic [63:0] SCALE_402MS = 64'h0400;

    // Ratio knees and per-segment intercept and slope.
    localparam logic [9:0] RATIO_KNEE [7] = '{
        10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a
    };
    localparam logic [9:0] INTERCEPT [8] = '{
        10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
    };
    localparam logic [9:0] SLOPE [8] = '{
        10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
    };

    // Register settings per random phase; gain data above one checks masking.
    localparam logic [1:0] PHASE_ITIME [NUM_PHASES] = '{
        2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd0
    };
    localparam logic [1:0] PHASE_GAIN [NUM_PHASES] = '{
        2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd1, 2'd0
    };

    typedef struct {
        logic [RAW_W-1:0] broadband;
        logic [RAW_W-1:0] infrared;
    } sample_t;

    typedef struct {
        logic [RAW_W-1:0] broadband;
        logic [RAW_W-1:0] infrared;
        logic [LUX_W-1:0] lux;
    } lux_rec_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [RAW_W-1:0]     broadband_count = '0;
    logic [RAW_W-1:0]     infrared_count = '0;
    logic                 done;
    logic [LUX_W-1:0]     lux;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Shadow copy of the block's registers, at their reset values.
    logic [1:0]           itime_setting = ITIME_NOMINAL;
    logic                 gain_setting = 1'b0;

    sample_t              pending_samples[$];
    lux_rec_t             expected_lux[$];
    lux_rec_t             oldest_lux;
    int                   sender_idle_pct = 21;
    int                   mismatches = 0;

    ambient_light_lux_calc u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .broadband_count (broadband_count),
        .infrared_count  (infrared_count),
        .done            (done),
        .lux             (lux),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Piecewise-linear lux fit on the normalized channel counts.
    function automatic logic [LUX_W-1:0] predict_lux(input logic [RAW_W-1:0] bb,
                                                     input logic [RAW_W-1:0] ir,
                                                     input logic [1:0] itime,
                                                     input logic gain);
        logic [63:0] scale;
        logic [63:0] ch0;
        logic [63:0] ch1;
        logic [63:0] ratio;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] diff;
        int          seg;
        if (itime == ITIME_FAST)
            scale = SCALE_13MS;
        else if (itime == ITIME_MID)
            scale = SCALE_101MS;
        else
            scale = SCALE_402MS;
        if (!gain)
            scale = scale << GAIN_SHIFT;
        ch0 = (64'(bb) * scale) >> SCALE_FRAC;
        ch1 = (64'(ir) * scale) >> SCALE_FRAC;
        // A zero broadband count takes the first segment.
        ratio = (ch0 != 0) ? (ch1 << (RATIO_FRAC + 1)) / ch0 : 64'd0;
        ratio = (ratio + 64'd1) >> 1;
        seg = 7;
        for (int k = 6; k >= 0; k--)
        begin
            if (ratio <= 64'(RATIO_KNEE[k]))
                seg = k;
        end
        pos = ch0 * 64'(INTERCEPT[seg]);
        neg = ch1 * 64'(SLOPE[seg]);
        diff = (neg >= pos) ? 64'd0 : pos - neg;
        return LUX_W'((diff + (64'd1 << (LUX_FRAC - 1))) >> LUX_FRAC);
    endfunction

    // Driver: takes samples off the pending queue and records each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            broadband_count <= '0;
            infrared_count <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_lux.push_back('{broadband_count, infrared_count,
                    predict_lux(broadband_count, infrared_count,
                                itime_setting, gain_setting)});
            if (start && busy)
            begin
                // Hold the sample until the block takes it.
            end
            else if (pending_samples.size() != 0 &&
                     $urandom_range(0, 99) >= sender_idle_pct)
            begin
                start <= 1'b1;
                broadband_count <= pending_samples[0].broadband;
                infrared_count <= pending_samples[0].infrared;
                pending_samples.delete(0);
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: compares each strobed result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_lux.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result: lux=%0d", lux);
            end
            else
            begin
                oldest_lux = expected_lux.pop_front();
                if (lux !== oldest_lux.lux)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Lux mismatch: bb=%0d ir=%0d expected=%0d actual=%0d",
                                 oldest_lux.broadband, oldest_lux.infrared,
                                 oldest_lux.lux, lux);
                end
            end
        end
    end

    // Blocks until every sample has been transferred and every result seen.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_samples.size() != 0 || start || expected_lux.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_ITIME)
            itime_setting = val;
        else
            gain_setting = val[0];
    endtask

    task automatic queue_sample(input int bb, input int ir);
        pending_samples.push_back('{RAW_W'(bb), RAW_W'(ir)});
    endtask

    // Stimulus: reset, directed corners, then random phases under new settings.
    initial
    begin
        int bb;
        int ir;
        int mode;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Corners at the reset settings: zero, one, full-scale and alternating-bit counts.
        queue_sample(0, 0);
        queue_sample(0, 65535);
        queue_sample(65535, 0);
        queue_sample(65535, 65535);
        queue_sample(1, 0);
        queue_sample(16'haaaa, 16'h5555);
        // Ratio above the last knee gives zero lux.
        queue_sample(100, 200);
        // A broadband count of 512 makes the rounded ratio equal the infrared count.
        for (int k = 0; k < 7; k++)
        begin
            queue_sample(512, RATIO_KNEE[k]);
            queue_sample(512, RATIO_KNEE[k] + 1);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Registers change only while the pipeline is empty.
            wait_drained();
            repeat (PIPE_LATENCY) @(negedge clk);
            write_reg(REG_ITIME, PHASE_ITIME[p]);
            write_reg(REG_GAIN, PHASE_GAIN[p]);
            @(posedge clk);
            cfg_we <= 1'b0;
            sender_idle_pct = (p < 3) ? 21 : (p < 6) ? 71 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                mode = $urandom_range(0, 9);
                if (mode < 3)
                begin
                    bb = $urandom_range(0, 65535);
                    ir = $urandom_range(0, 65535);
                end
                else if (mode < 8)
                begin
                    // Realistic pairs: infrared a fraction of broadband, across all segments.
                    bb = $urandom_range(0, 65535) >> $urandom_range(0, 15);
                    ir = (bb * $urandom_range(0, 1500)) / 1000;
                    if (ir > 65535)
                        ir = 65535;
                end
                else if (mode == 8)
                begin
                    bb = $urandom_range(0, 15);
                    ir = $urandom_range(0, 15);
                end
                else
                begin
                    bb = ($urandom_range(0, 1) != 0) ? 65535 : 0;
                    ir = ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(0, 65535);
                end
                queue_sample(bb, ir);
            end
        end

        wait_drained();
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (mismatches == 0 && expected_lux.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog against a hung pipeline.
    initial
    begin
        #(CLK_PERIOD * 300000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
